@@ rtl/alik_pkg.sv @@
// ----------------------------------------------------------------------------
// alik_pkg
// Shared types and constants for the ankle linkage inverse kinematics unit.
// ----------------------------------------------------------------------------
package alik_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRIG_ROLL,
    ST_TRIG_PITCH,
    ST_MAC,
    ST_TRIG_TH,
    ST_SQRT,
    ST_DIV,
    ST_OUT
  } alik_state_t;

  typedef enum logic [3:0] {
    JOB_Y1,
    JOB_Z1,
    JOB_PX,
    JOB_PZ,
    JOB_TX,
    JOB_TZ,
    JOB_SQ
  } alik_job_t;

  // configuration register indexes
  localparam logic [2:0] REG_CRANK_OFFSET   = 3'd0;
  localparam logic [2:0] REG_PIVOT_HEIGHT_F = 3'd1;
  localparam logic [2:0] REG_PIVOT_HEIGHT_E = 3'd2;
  localparam logic [2:0] REG_ROD_LENGTH_F   = 3'd3;
  localparam logic [2:0] REG_ROD_LENGTH_E   = 3'd4;
  localparam logic [2:0] REG_CRANK_RADIUS_E = 3'd5;
  localparam logic [2:0] REG_CRANK_RADIUS_F = 3'd6;

  // trig in Q30
  localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam int                 CORDIC_STEPS = 30;

  // geometry in Q8 mm
  localparam logic signed [21:0] FOOT_X  = -22'sd17664;
  localparam logic signed [21:0] FOOT_Y  = 22'sd8960;
  localparam logic signed [21:0] FOOT_Z  = -22'sd6415;
  localparam logic signed [21:0] PIVOT_X = -22'sd5632;

  localparam logic signed [31:0] ANG_SAT = 32'sd205887;
  localparam logic signed [19:0] DSTEP   = 20'sd64;

  function automatic logic [35:0] atan_q30(input logic [4:0] i);
    logic [35:0] v;
    case (i)
      5'd0:  v = 36'h03243F6A8;
      5'd1:  v = 36'h01DAC6705;
      5'd2:  v = 36'h00FADBAFC;
      5'd3:  v = 36'h007F56EA6;
      5'd4:  v = 36'h003FEAB76;
      5'd5:  v = 36'h001FFD55B;
      5'd6:  v = 36'h000FFFAAA;
      5'd7:  v = 36'h0007FFF55;
      5'd8:  v = 36'h0003FFFEA;
      5'd9:  v = 36'h0001FFFFD;
      5'd10: v = 36'h0000FFFFF;
      5'd11: v = 36'h00007FFFF;
      5'd12: v = 36'h00003FFFF;
      5'd13: v = 36'h00001FFFF;
      5'd14: v = 36'h00000FFFF;
      5'd15: v = 36'h000007FFF;
      5'd16: v = 36'h000003FFF;
      5'd17: v = 36'h000001FFF;
      5'd18: v = 36'h000000FFF;
      5'd19: v = 36'h0000007FF;
      5'd20: v = 36'h0000003FF;
      5'd21: v = 36'h0000001FF;
      5'd22: v = 36'h0000000FF;
      5'd23: v = 36'h00000007F;
      5'd24: v = 36'h00000003F;
      5'd25: v = 36'h00000001F;
      5'd26: v = 36'h00000000F;
      5'd27: v = 36'h000000007;
      5'd28: v = 36'h000000003;
      5'd29: v = 36'h000000001;
      default: v = 36'h000000000;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/alik_cordic.sv @@
// ----------------------------------------------------------------------------
// alik_cordic
// Rotation-mode CORDIC, one micro-rotation per cycle, gives cos and sin in Q30.
// ----------------------------------------------------------------------------
module alik_cordic import alik_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [19:0] ang,
  output logic               done,
  output logic signed [31:0] cos_out,
  output logic signed [31:0] sin_out
);

  logic signed [33:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [35:0] z_r, z_nxt, z0;
  logic [4:0]         i_r, i_nxt;
  logic               flip_r, flip_nxt, busy_r, busy_nxt, done_r, done_nxt;
  logic signed [31:0] cos_r, cos_nxt, sin_r, sin_nxt;
  logic signed [33:0] dx, dy;
  logic signed [35:0] at;

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    i_nxt    = i_r;
    flip_nxt = flip_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cos_nxt  = cos_r;
    sin_nxt  = sin_r;
    z0       = {{2{ang[19]}}, ang, 14'b0};
    dx       = y_r >>> i_r;
    dy       = x_r >>> i_r;
    at       = signed'(atan_q30(i_r));
    if (start) begin
      x_nxt    = CORDIC_GAIN;
      y_nxt    = '0;
      i_nxt    = '0;
      busy_nxt = 1'b1;
      // fold once into [-pi/2, pi/2]
      if (z0 > HALF_PI_Q30) begin
        z_nxt    = z0 - PI_Q30;
        flip_nxt = 1'b1;
      end else if (z0 < -HALF_PI_Q30) begin
        z_nxt    = z0 + PI_Q30;
        flip_nxt = 1'b1;
      end else begin
        z_nxt    = z0;
        flip_nxt = 1'b0;
      end
    end else if (busy_r) begin
      if (!z_r[35]) begin
        x_nxt = x_r - dx;
        y_nxt = y_r + dy;
        z_nxt = z_r - at;
      end else begin
        x_nxt = x_r + dx;
        y_nxt = y_r - dy;
        z_nxt = z_r + at;
      end
      i_nxt = i_r + 5'd1;
      if (i_r == 5'(CORDIC_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        cos_nxt  = flip_r ? 32'(-x_nxt) : 32'(x_nxt);
        sin_nxt  = flip_r ? 32'(-y_nxt) : 32'(y_nxt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    i_r    <= i_nxt;
    flip_r <= flip_nxt;
    cos_r  <= cos_nxt;
    sin_r  <= sin_nxt;
  end

  assign done    = done_r;
  assign cos_out = cos_r;
  assign sin_out = sin_r;

endmodule

@@ rtl/alik_sqrt.sv @@
// ----------------------------------------------------------------------------
// alik_sqrt
// Digit-by-digit square root of a 44-bit value, rounded to nearest.
// ----------------------------------------------------------------------------
module alik_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [43:0] n_in,
  output logic        done,
  output logic [22:0] root
);

  logic [44:0] n_r, n_nxt, r_r, r_nxt, bitv, trial;
  logic [4:0]  k_r, k_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [22:0] root_r, root_nxt;

  always_comb begin
    n_nxt    = n_r;
    r_nxt    = r_r;
    k_nxt    = k_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    root_nxt = root_r;
    bitv     = 45'd1 << {k_r, 1'b0};
    trial    = r_r + bitv;
    if (start) begin
      n_nxt    = {1'b0, n_in};
      r_nxt    = '0;
      k_nxt    = 5'd22;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (n_r >= trial) begin
        n_nxt = n_r - trial;
        r_nxt = (r_r >> 1) + bitv;
      end else begin
        r_nxt = r_r >> 1;
      end
      k_nxt = k_r - 5'd1;
      if (k_r == 5'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        root_nxt = (n_nxt > r_nxt) ? 23'(r_nxt + 45'd1) : 23'(r_nxt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    n_r    <= n_nxt;
    r_r    <= r_nxt;
    k_r    <= k_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

@@ rtl/alik_div.sv @@
// ----------------------------------------------------------------------------
// alik_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module alik_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [29:0] num,
  input  logic [24:0] den,
  output logic        done,
  output logic [29:0] quo
);

  logic [25:0] rem_r, rem_nxt, trial;
  logic [29:0] quo_r, quo_nxt, nsh_r, nsh_nxt;
  logic [24:0] den_r, den_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    nsh_nxt  = nsh_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[24:0], nsh_r[29]};
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = '0;
      nsh_nxt  = num;
      den_nxt  = den;
      cnt_nxt  = 5'd29;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        quo_nxt = {quo_r[28:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[28:0], 1'b0};
      end
      nsh_nxt = {nsh_r[28:0], 1'b0};
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    nsh_r <= nsh_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

@@ rtl/ankle_linkage_inverse_kinematics_unit.sv @@
// ----------------------------------------------------------------------------
// ankle_linkage_inverse_kinematics_unit
// Foot pitch/roll in, two crank angles out, by Newton iteration per crank.
// ----------------------------------------------------------------------------
//  channel | ports                      | contents
//  in      | in_tvalid/tready/tdata     | pitch_angle, roll_angle
//  out     | out_tvalid/tready/tdata    | angle_f, angle_e, converged_f, converged_e
//  cfg     | cfg_we/cfg_addr/cfg_wdata  | seven geometry registers
//
//  a request first computes the foot points, then runs Newton steps per crank
//  (a full step runs two 30-step CORDIC runs, two 23-step roots and one 30-step
//  divide, on the shared 32x22 multiplier), and then passes through the output
//  state; each crank stops after at most ITER_LIMIT Newton steps.
//  in_tready is high only while idle; a finished result waits in the output
//  register and the next request may be accepted meanwhile.
//  rst_n is synchronous; it clears the state, output valid and geometry registers, not the datapath.
// ----------------------------------------------------------------------------
module ankle_linkage_inverse_kinematics_unit import alik_pkg::*; #(
  parameter int ITER_LIMIT = 100
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // pitch_angle[18:0], roll_angle[37:19]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // angle_f, angle_e, converged_f, converged_e
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [18:0] cfg_wdata
);

  localparam int IT_W = $clog2(ITER_LIMIT + 1);

  alik_state_t state_r, state_nxt;
  alik_job_t   job_r, job_nxt;

  logic [17:0]        crank_offset_r, rod_f_r, rod_e_r, rad_e_r, rad_f_r;
  logic signed [18:0] piv_f_r, piv_e_r;

  logic signed [18:0] pitch_r, pitch_nxt;
  logic signed [31:0] cr_r, cr_nxt, sr_r, sr_nxt, cp_r, cp_nxt, sp_r, sp_nxt;
  logic signed [31:0] c_r, c_nxt, s_r, s_nxt;
  logic signed [19:0] y1_r, y1_nxt, z1_r, z1_nxt;
  logic signed [19:0] px_r [2], py_r [2], pz_r [2];
  logic signed [19:0] px_nxt, py_nxt, pz_nxt;
  logic               pt_we;
  logic signed [21:0] tx_r, tx_nxt, tz_r, tz_nxt;
  logic               side_r, side_nxt, probe_r, probe_nxt, sgn_r, sgn_nxt;
  logic [IT_W-1:0]    it_r, it_nxt;
  logic signed [18:0] theta_r, theta_nxt;
  logic signed [23:0] fx_r, fx_nxt;
  logic signed [18:0] ang_r [2];
  logic               conv_r [2];
  logic               fin, fin_conv;
  logic signed [18:0] fin_ang;

  logic [2:0]         cnt_r, cnt_nxt, nterms;
  logic signed [53:0] p_r, p_nxt, prod;
  logic               pv_r, pv_nxt;
  logic signed [55:0] acc_r, acc_nxt, acc_rnd;
  logic signed [21:0] rnd;
  logic signed [31:0] mul_a;
  logic signed [21:0] mul_b, y0, dxv, dyv, dzv, ty;

  logic               out_valid_r, out_valid_nxt;
  logic [39:0]        out_data_r, out_data_nxt;

  logic               cor_start, cor_done, sq_start, sq_done, dv_start, dv_done;
  logic signed [19:0] cor_ang;
  logic signed [31:0] cor_cos, cor_sin;
  logic [22:0]        root;
  logic [29:0]        quo, dv_num;
  logic [24:0]        dv_den;
  logic signed [23:0] res;
  logic signed [24:0] diff;
  logic [22:0]        fx_abs;
  logic [24:0]        diff_abs;
  logic signed [31:0] xn;
  logic [17:0]        rad_s, rod_s;
  logic signed [18:0] piv_s;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crank_offset_r <= '0;
      piv_f_r        <= '0;
      piv_e_r        <= '0;
      rod_f_r        <= '0;
      rod_e_r        <= '0;
      rad_e_r        <= '0;
      rad_f_r        <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_CRANK_OFFSET:   crank_offset_r <= cfg_wdata[17:0];
        REG_PIVOT_HEIGHT_F: piv_f_r        <= signed'(cfg_wdata);
        REG_PIVOT_HEIGHT_E: piv_e_r        <= signed'(cfg_wdata);
        REG_ROD_LENGTH_F:   rod_f_r        <= cfg_wdata[17:0];
        REG_ROD_LENGTH_E:   rod_e_r        <= cfg_wdata[17:0];
        REG_CRANK_RADIUS_E: rad_e_r        <= cfg_wdata[17:0];
        REG_CRANK_RADIUS_F: rad_f_r        <= cfg_wdata[17:0];
        default: ;
      endcase
    end
  end

  alik_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cor_start),
    .ang     (cor_ang),
    .done    (cor_done),
    .cos_out (cor_cos),
    .sin_out (cor_sin)
  );

  alik_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .n_in  (acc_r[43:0]),
    .done  (sq_done),
    .root  (root)
  );

  alik_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dv_start),
    .num   (dv_num),
    .den   (dv_den),
    .done  (dv_done),
    .quo   (quo)
  );

  // per-crank selections: side 0 is crank F with foot point D
  assign rad_s = side_r ? rad_e_r : rad_f_r;
  assign rod_s = side_r ? rod_e_r : rod_f_r;
  assign piv_s = side_r ? piv_e_r : piv_f_r;
  assign y0    = side_r ? FOOT_Y : -FOOT_Y;
  assign ty    = side_r ? signed'({4'b0, crank_offset_r})
                        : -signed'({4'b0, crank_offset_r});
  assign dxv   = 22'(px_r[side_r]) - tx_r;
  assign dyv   = 22'(py_r[side_r]) - ty;
  assign dzv   = 22'(pz_r[side_r]) - tz_r;

  // operand select for the shared multiplier
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    nterms = 3'd2;
    case (job_r)
      JOB_Y1: begin
        mul_a = (cnt_r == 3'd0) ? cr_r : sr_r;
        mul_b = (cnt_r == 3'd0) ? y0 : -FOOT_Z;
      end
      JOB_Z1: begin
        mul_a = (cnt_r == 3'd0) ? sr_r : cr_r;
        mul_b = (cnt_r == 3'd0) ? y0 : FOOT_Z;
      end
      JOB_PX: begin
        mul_a = (cnt_r == 3'd0) ? cp_r : sp_r;
        mul_b = (cnt_r == 3'd0) ? FOOT_X : 22'(z1_r);
      end
      JOB_PZ: begin
        mul_a = (cnt_r == 3'd0) ? sp_r : cp_r;
        mul_b = (cnt_r == 3'd0) ? -FOOT_X : 22'(z1_r);
      end
      JOB_TX: begin
        nterms = 3'd1;
        mul_a  = c_r;
        mul_b  = -signed'({4'b0, rad_s});
      end
      JOB_TZ: begin
        nterms = 3'd1;
        mul_a  = s_r;
        mul_b  = signed'({4'b0, rad_s});
      end
      JOB_SQ: begin
        nterms = 3'd3;
        case (cnt_r)
          3'd0:    begin mul_a = 32'(dxv); mul_b = dxv; end
          3'd1:    begin mul_a = 32'(dyv); mul_b = dyv; end
          default: begin mul_a = 32'(dzv); mul_b = dzv; end
        endcase
      end
      default: ;
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign acc_rnd = acc_r + (56'sd1 <<< 29);
  assign rnd     = acc_rnd[51:30];

  assign res      = signed'({1'b0, root}) - signed'({6'b0, rod_s});
  assign diff     = 25'(res) - 25'(fx_r);
  assign fx_abs   = fx_r[23] ? 23'(-fx_r) : 23'(fx_r);
  assign diff_abs = diff[24] ? 25'(-diff) : 25'(diff);
  assign dv_num   = {1'b0, fx_abs, 6'b0} + 30'(diff_abs >> 1);
  assign dv_den   = diff_abs;
  assign xn       = sgn_r ? 32'(theta_r) + signed'({2'b0, quo})
                          : 32'(theta_r) - signed'({2'b0, quo});

  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    pitch_nxt     = pitch_r;
    cr_nxt        = cr_r;
    sr_nxt        = sr_r;
    cp_nxt        = cp_r;
    sp_nxt        = sp_r;
    c_nxt         = c_r;
    s_nxt         = s_r;
    y1_nxt        = y1_r;
    z1_nxt        = z1_r;
    px_nxt        = '0;
    py_nxt        = '0;
    pz_nxt        = '0;
    pt_we         = 1'b0;
    tx_nxt        = tx_r;
    tz_nxt        = tz_r;
    side_nxt      = side_r;
    probe_nxt     = probe_r;
    sgn_nxt       = sgn_r;
    it_nxt        = it_r;
    theta_nxt     = theta_r;
    fx_nxt        = fx_r;
    fin           = 1'b0;
    fin_conv      = 1'b0;
    fin_ang       = theta_r;
    cnt_nxt       = cnt_r + 3'd1;
    p_nxt         = p_r;
    pv_nxt        = 1'b0;
    acc_nxt       = pv_r ? acc_r + 56'(p_r) : acc_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    cor_start     = 1'b0;
    cor_ang       = 20'(theta_r);
    sq_start      = 1'b0;
    dv_start      = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (cnt_r < nterms) begin
      p_nxt  = prod;
      pv_nxt = 1'b1;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          pitch_nxt = signed'(in_tdata[18:0]);
          cor_start = 1'b1;
          cor_ang   = 20'(signed'(in_tdata[37:19]));
          state_nxt = ST_TRIG_ROLL;
        end
      end
      ST_TRIG_ROLL: begin
        if (cor_done) begin
          cr_nxt    = cor_cos;
          sr_nxt    = cor_sin;
          cor_start = 1'b1;
          cor_ang   = 20'(pitch_r);
          state_nxt = ST_TRIG_PITCH;
        end
      end
      ST_TRIG_PITCH: begin
        if (cor_done) begin
          cp_nxt    = cor_cos;
          sp_nxt    = cor_sin;
          side_nxt  = 1'b0;
          job_nxt   = JOB_Y1;
          cnt_nxt   = '0;
          acc_nxt   = '0;
          pv_nxt    = 1'b0;
          state_nxt = ST_MAC;
        end
      end
      ST_MAC: begin
        if (cnt_r == nterms + 3'd1) begin
          cnt_nxt = '0;
          acc_nxt = '0;
          pv_nxt  = 1'b0;
          case (job_r)
            JOB_Y1: begin
              y1_nxt  = 20'(rnd);
              job_nxt = JOB_Z1;
            end
            JOB_Z1: begin
              z1_nxt  = 20'(rnd);
              job_nxt = JOB_PX;
            end
            JOB_PX: begin
              tx_nxt  = rnd;
              job_nxt = JOB_PZ;
            end
            JOB_PZ: begin
              pt_we   = 1'b1;
              px_nxt  = 20'(tx_r);
              py_nxt  = y1_r;
              pz_nxt  = 20'(rnd);
              if (!side_r) begin
                side_nxt = 1'b1;
                job_nxt  = JOB_Y1;
              end else begin
                side_nxt  = 1'b0;
                theta_nxt = '0;
                it_nxt    = '0;
                probe_nxt = 1'b0;
                cor_start = 1'b1;
                cor_ang   = '0;
                state_nxt = ST_TRIG_TH;
              end
            end
            JOB_TX: begin
              tx_nxt  = rnd + PIVOT_X;
              job_nxt = JOB_TZ;
            end
            JOB_TZ: begin
              tz_nxt  = rnd + 22'(piv_s);
              job_nxt = JOB_SQ;
            end
            default: begin
              acc_nxt   = acc_r;
              sq_start  = 1'b1;
              state_nxt = ST_SQRT;
            end
          endcase
        end
      end
      ST_TRIG_TH: begin
        if (cor_done) begin
          c_nxt     = cor_cos;
          s_nxt     = cor_sin;
          job_nxt   = JOB_TX;
          cnt_nxt   = '0;
          acc_nxt   = '0;
          pv_nxt    = 1'b0;
          state_nxt = ST_MAC;
        end
      end
      ST_SQRT: begin
        acc_nxt = acc_r;
        if (sq_done) begin
          if (!probe_r) begin
            if (res == '0) begin
              fin      = 1'b1;
              fin_conv = 1'b1;
            end else begin
              fx_nxt    = res;
              probe_nxt = 1'b1;
              cor_start = 1'b1;
              cor_ang   = 20'(theta_r) + DSTEP;
              state_nxt = ST_TRIG_TH;
            end
          end else if (diff == '0) begin
            fin = 1'b1;
          end else begin
            sgn_nxt   = fx_r[23] != diff[24];
            dv_start  = 1'b1;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (dv_done) begin
          if (quo == '0) begin
            fin      = 1'b1;
            fin_conv = 1'b1;
          end else begin
            if (xn > ANG_SAT) begin
              theta_nxt = 19'(ANG_SAT);
            end else if (xn < -ANG_SAT) begin
              theta_nxt = 19'(-ANG_SAT);
            end else begin
              theta_nxt = 19'(xn);
            end
            it_nxt = it_r + 1'b1;
            if (it_nxt == IT_W'(ITER_LIMIT)) begin
              fin     = 1'b1;
              fin_ang = theta_nxt;
            end else begin
              probe_nxt = 1'b0;
              cor_start = 1'b1;
              cor_ang   = 20'(theta_nxt);
              state_nxt = ST_TRIG_TH;
            end
          end
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {conv_r[1], conv_r[0], ang_r[1], ang_r[0]};
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // crank solve finished: start the other crank or hand off
    if (fin) begin
      if (!side_r) begin
        side_nxt  = 1'b1;
        theta_nxt = '0;
        it_nxt    = '0;
        probe_nxt = 1'b0;
        cor_start = 1'b1;
        cor_ang   = '0;
        state_nxt = ST_TRIG_TH;
      end else begin
        state_nxt = ST_OUT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    job_r      <= job_nxt;
    pitch_r    <= pitch_nxt;
    cr_r       <= cr_nxt;
    sr_r       <= sr_nxt;
    cp_r       <= cp_nxt;
    sp_r       <= sp_nxt;
    c_r        <= c_nxt;
    s_r        <= s_nxt;
    y1_r       <= y1_nxt;
    z1_r       <= z1_nxt;
    tx_r       <= tx_nxt;
    tz_r       <= tz_nxt;
    side_r     <= side_nxt;
    probe_r    <= probe_nxt;
    sgn_r      <= sgn_nxt;
    it_r       <= it_nxt;
    theta_r    <= theta_nxt;
    fx_r       <= fx_nxt;
    cnt_r      <= cnt_nxt;
    p_r        <= p_nxt;
    pv_r       <= pv_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
    if (pt_we) begin
      px_r[side_r] <= px_nxt;
      py_r[side_r] <= py_nxt;
      pz_r[side_r] <= pz_nxt;
    end
    if (fin) begin
      ang_r[side_r]  <= fin_ang;
      conv_r[side_r] <= fin_conv;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ test/tb_ankle_linkage_inverse_kinematics_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ankle_linkage_inverse_kinematics_unit
// Drives pitch/roll requests under several linkage geometries and checks each
// pair of solved crank angles and convergence flags against a bit-exact
// fixed-point Newton solver kept in the bench, with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_ankle_linkage_inverse_kinematics_unit;
  import alik_pkg::*;

  localparam longint ANGLE_LIMIT = 205887;
  localparam longint PI_FIX      = 64'sd3373259426;
  localparam longint HALF_PI_FIX = 1686629713;
  localparam longint GAIN_FIX    = 652032874;
  localparam longint FX          = -17664;
  localparam longint FY          = 8960;
  localparam longint FZ          = -6415;
  localparam longint PX0         = -5632;
  localparam longint DIFF_STEP   = 64;
  localparam int     NEWTON_MAX  = 100;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [18:0] cfg_wdata = '0;

  ankle_linkage_inverse_kinematics_unit dut (.*);

  always #1 clk = ~clk;

  // geometry copy used by the solver
  longint geo_offset, geo_pivot_f, geo_pivot_e, geo_rod_f, geo_rod_e, geo_rad_e, geo_rad_f;

  logic [39:0] solved_q[$];
  int          errors = 0;
  bit          stall_enable = 1'b0;

  longint atan_tab[30] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
    64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000007, 64'h00000003, 64'h00000001};

  function automatic longint round_q30(input longint acc);
    return (acc + (64'sd1 <<< 29)) >>> 30;
  endfunction

  task automatic rotate_trig(input longint ang, output longint c, output longint s);
    longint z, x, y, dx, dy;
    bit flip;
    z = ang * 16384;
    x = GAIN_FIX;
    y = 0;
    flip = 1'b0;
    if (z > HALF_PI_FIX) begin
      z -= PI_FIX; flip = 1'b1;
    end else if (z < -HALF_PI_FIX) begin
      z += PI_FIX; flip = 1'b1;
    end
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = x;
    s = y;
  endtask

  function automatic longint rounded_root(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b; r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    if (n > r) r++;
    return longint'(r);
  endfunction

  task automatic foot_point(input longint y0, input longint pitch, input longint roll,
                            output longint px, output longint py, output longint pz);
    longint cr, sr, cp, sp, z1;
    rotate_trig(roll, cr, sr);
    rotate_trig(pitch, cp, sp);
    py = round_q30(cr * y0 - sr * FZ);
    z1 = round_q30(sr * y0 + cr * FZ);
    px = round_q30(cp * FX + sp * z1);
    pz = round_q30(-sp * FX + cp * z1);
  endtask

  task automatic rod_error(input longint px, py, pz, theta, radius, ty, pivot, rod,
                           output longint err);
    longint c, s, dx, dy, dz;
    longint unsigned sq;
    rotate_trig(theta, c, s);
    dx = px - (round_q30(-c * radius) + PX0);
    dy = py - ty;
    dz = pz - (round_q30(s * radius) + pivot);
    sq = longint'(dx * dx) + longint'(dy * dy) + longint'(dz * dz);
    err = rounded_root(sq) - rod;
  endtask

  task automatic solve_crank(input longint px, py, pz, radius, ty, pivot, rod,
                             output longint ang, output bit ok);
    longint x, fx, f2, diff, stp;
    longint unsigned num, den, q;
    x = 0;
    ok = 1'b0;
    for (int i = 0; i < NEWTON_MAX; i++) begin
      rod_error(px, py, pz, x, radius, ty, pivot, rod, fx);
      if (fx == 0) begin
        ok = 1'b1; break;
      end
      rod_error(px, py, pz, x + DIFF_STEP, radius, ty, pivot, rod, f2);
      diff = f2 - fx;
      if (diff == 0) break;
      num = longint'(fx < 0 ? -fx : fx) * DIFF_STEP;
      den = longint'(diff < 0 ? -diff : diff);
      q = (num + den / 2) / den;
      stp = ((fx < 0) != (diff < 0)) ? -longint'(q) : longint'(q);
      if (stp == 0) begin
        ok = 1'b1; break;
      end
      x = x - stp;
      if (x > ANGLE_LIMIT) x = ANGLE_LIMIT;
      if (x < -ANGLE_LIMIT) x = -ANGLE_LIMIT;
    end
    ang = x;
  endtask

  task automatic solve_ankle(input logic signed [18:0] pitch, input logic signed [18:0] roll,
                             output logic [39:0] word);
    longint dx, dy, dz, cx, cy, cz, af, ae;
    bit okf, oke;
    logic [18:0] uf, ue;
    foot_point(-FY, pitch, roll, dx, dy, dz);
    foot_point(FY, pitch, roll, cx, cy, cz);
    solve_crank(dx, dy, dz, geo_rad_f, -geo_offset, geo_pivot_f, geo_rod_f, af, okf);
    solve_crank(cx, cy, cz, geo_rad_e, geo_offset, geo_pivot_e, geo_rod_e, ae, oke);
    uf = af[18:0];
    ue = ae[18:0];
    word = {oke, okf, ue, uf};
  endtask

  // ---------------- stimulus helpers ----------------
  task automatic write_reg(input logic [2:0] idx, input logic [18:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_CRANK_OFFSET:   geo_offset  = longint'(val[17:0]);
      REG_PIVOT_HEIGHT_F: geo_pivot_f = longint'($signed(val));
      REG_PIVOT_HEIGHT_E: geo_pivot_e = longint'($signed(val));
      REG_ROD_LENGTH_F:   geo_rod_f   = longint'(val[17:0]);
      REG_ROD_LENGTH_E:   geo_rod_e   = longint'(val[17:0]);
      REG_CRANK_RADIUS_E: geo_rad_e   = longint'(val[17:0]);
      REG_CRANK_RADIUS_F: geo_rad_f   = longint'(val[17:0]);
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_geometry(input logic [18:0] d1, pf, pe, rf, re, cre, crf);
    write_reg(REG_CRANK_OFFSET, d1);
    write_reg(REG_PIVOT_HEIGHT_F, pf);
    write_reg(REG_PIVOT_HEIGHT_E, pe);
    write_reg(REG_ROD_LENGTH_F, rf);
    write_reg(REG_ROD_LENGTH_E, re);
    write_reg(REG_CRANK_RADIUS_E, cre);
    write_reg(REG_CRANK_RADIUS_F, crf);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // leaves valid high; the caller lowers it when a gap follows
  task automatic send_pose(input logic signed [18:0] pitch, input logic signed [18:0] roll);
    logic [39:0] word;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, roll, pitch};
    do @(posedge clk); while (!in_tready);
    solve_ankle(pitch, roll, word);
    solved_q.push_back(word);
  endtask

  task automatic idle_gap(input int n);
    @(negedge clk);
    in_tvalid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic wait_drained();
    idle_gap(0);
    while (solved_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic logic signed [18:0] rand_angle(input int span);
    return 19'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  // burst of random requests: mostly moderate poses, some over the full range
  task automatic random_burst(input int count);
    int left, span;
    left = count;
    while (left > 0) begin
      for (int b = $urandom_range(1, 6); b > 0 && left > 0; b--) begin
        span = ($urandom_range(0, 4) == 0) ? int'(ANGLE_LIMIT) : 40000;
        send_pose(rand_angle(span), rand_angle(span));
        left--;
      end
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(0, 40));
    end
  endtask

  // ---------------- tests ----------------
  task automatic test_reset_geometry();
    send_pose(19'sd0, 19'sd0);
    send_pose(19'sd205887, -19'sd205887);
    wait_drained();
  endtask

  task automatic test_directed_poses();
    logic signed [18:0] edges[10] = '{19'sd0, 19'sd1, -19'sd1, 19'sd102943, 19'sd102944,
                                      -19'sd102944, 19'sd205887, -19'sd205887,
                                      19'sd20000, -19'sd30000};
    set_geometry(19'd8960, 19'd25600, 19'd25600, 19'd32064, 19'd32064, 19'd10240, 19'd10240);
    for (int i = 0; i < 10; i++) begin
      send_pose(edges[i], edges[(i * 3 + 1) % 10]);
      if (i % 3 == 2) idle_gap($urandom_range(1, 20));
    end
    wait_drained();
  endtask

  task automatic test_extreme_geometry();
    // far out of reach: iteration limit and saturation
    set_geometry(19'd262143, 19'h40000, 19'h3FFFF, 19'd262143, 19'd0, 19'd262143, 19'd1);
    send_pose(19'sd0, 19'sd0);
    send_pose(19'sd5000, -19'sd5000);
    wait_drained();
  endtask

  task automatic test_random_nominal();
    set_geometry(19'd8960, 19'd25600, 19'd24000, 19'd32064, 19'd31500, 19'd10240, 19'd9800);
    random_burst(50);
    // hold off until everything is back, then go on
    wait_drained();
    random_burst(20);
    wait_drained();
  endtask

  task automatic test_random_geometry();
    logic [18:0] rad, piv;
    for (int k = 0; k < 4; k++) begin
      rad = 19'($urandom_range(5000, 15000));
      piv = 19'($urandom_range(15000, 40000));
      set_geometry(19'($urandom_range(4000, 14000)), piv,
                   (k[0]) ? -piv : piv + 19'd500,
                   19'($urandom_range(26000, 40000)), 19'($urandom_range(26000, 40000)),
                   rad, rad + 19'($urandom_range(0, 2000)));
      random_burst(20);
      wait_drained();
    end
  endtask

  // ---------------- receiver and checker ----------------
  initial begin
    forever begin
      @(negedge clk);
      if (!stall_enable) out_tready <= 1'b1;
      else out_tready <= ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 3000) == 0) stall_enable = !stall_enable;
    end
  end

  always @(posedge clk) begin
    logic [39:0] exp_w;
    if (rst_n && out_tvalid && out_tready) begin
      if (solved_q.size() == 0) begin
        $display("%t unexpected result expected none actual %h", $realtime, out_tdata);
        errors++;
      end else begin
        exp_w = solved_q.pop_front();
        if (out_tdata[18:0] !== exp_w[18:0]) begin
          $display("%t angle_f expected %0d actual %0d", $realtime,
                   $signed(exp_w[18:0]), $signed(out_tdata[18:0]));
          errors++;
        end
        if (out_tdata[37:19] !== exp_w[37:19]) begin
          $display("%t angle_e expected %0d actual %0d", $realtime,
                   $signed(exp_w[37:19]), $signed(out_tdata[37:19]));
          errors++;
        end
        if (out_tdata[38] !== exp_w[38]) begin
          $display("%t converged_f expected %b actual %b", $realtime, exp_w[38], out_tdata[38]);
          errors++;
        end
        if (out_tdata[39] !== exp_w[39]) begin
          $display("%t converged_e expected %b actual %b", $realtime, exp_w[39], out_tdata[39]);
          errors++;
        end
      end
    end
  end

  initial begin
    #60000000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    geo_offset = 0; geo_pivot_f = 0; geo_pivot_e = 0;
    geo_rod_f = 0; geo_rod_e = 0; geo_rad_e = 0; geo_rad_f = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    stall_enable = 1'b1;
    test_reset_geometry();
    test_directed_poses();
    test_extreme_geometry();
    test_random_nominal();
    test_random_geometry();
    wait_drained();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ ankle_linkage_inverse_kinematics_unit.f @@
rtl/alik_pkg.sv
rtl/alik_cordic.sv
rtl/alik_sqrt.sv
rtl/alik_div.sv
rtl/ankle_linkage_inverse_kinematics_unit.sv
test/tb_ankle_linkage_inverse_kinematics_unit.sv
